@@ rtl/skf_pkg.sv @@
// shared widths, constants and register indexes of the scalar kalman filter
package skf_pkg;

  localparam int CH_W   = 3;
  localparam int MEAS_W = 32;
  localparam int VAR_W  = 24;
  localparam int GAIN_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int NUM_CHANNELS_DEF = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE  = 2'd2;

  // reset values
  localparam logic [VAR_W-1:0]  PROCESS_NOISE_RST     = 24'd1311;
  localparam logic [VAR_W-1:0]  MEASUREMENT_NOISE_RST = 24'd3277;
  localparam logic [MEAS_W-1:0] INITIAL_ESTIMATE_RST  = 32'd0;

  localparam logic [VAR_W-1:0]  VAR_ONE  = 24'd65536;
  localparam logic [VAR_W-1:0]  VAR_MAX  = 24'hFFFFFF;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  // one quotient bit per step
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

endpackage

@@ rtl/skf_in_if.sv @@
// measurement request channel
interface skf_in_if import skf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [MEAS_W-1:0] measurement;

  modport source (output valid, output channel, output measurement, input ready);
  modport sink   (input valid, input channel, input measurement, output ready);
endinterface

@@ rtl/skf_out_if.sv @@
// filter result channel
interface skf_out_if import skf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel_out;
  logic [MEAS_W-1:0] estimate;
  logic [GAIN_W-1:0] gain;

  modport source (output valid, output channel_out, output estimate, output gain,
                  input ready);
  modport sink   (input valid, input channel_out, input estimate, input gain,
                  output ready);
endinterface

@@ rtl/skf_cfg_if.sv @@
// configuration write channel
interface skf_cfg_if import skf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/scalar_kalman_filter_core.sv @@
// scalar kalman filter: per-channel estimate/variance store and a shared divide/multiply sequencer
// sequence per request: read, init, 17 divide steps, two passes through the one 18x34
//   multiplier, update; a zero denominator skips the divide; a stalled output holds the update
// new requests are accepted only in the idle state, so the divider works on one request at a time
// out-of-range channels are accepted and dropped with no result
// reset (rst_n low, synchronous): default registers, all channels reloaded, no result pending
module scalar_kalman_filter_core import skf_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  skf_in_if.sink    in_ch,
  skf_out_if.source out_ch,
  skf_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int EXT_W = CH_W + IDX_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // configuration registers
  logic [VAR_W-1:0]  q_r;
  logic [VAR_W-1:0]  r_r;
  logic [MEAS_W-1:0] init_est_r;

  // per-channel stores; an entry not yet written since reset or reload reads as init_est_r and VAR_ONE
  logic [MEAS_W-1:0] est_mem [NUM_CHANNELS];
  logic [VAR_W-1:0]  var_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;

  logic [MEAS_W-1:0] est_rd_r;
  logic [VAR_W-1:0]  var_rd_r;
  logic              vld_rd_r;

  // item registers
  logic [CH_W-1:0]   ch_r;
  logic [IDX_W-1:0]  idx_r;
  logic [MEAS_W-1:0] meas_r;
  logic [MEAS_W-1:0] x_r;
  logic [VAR_W-1:0]  pp_r;
  logic [VAR_W:0]    den_r;
  logic [VAR_W:0]    rem_r;
  logic [GAIN_W-1:0] quo_r;        // low numerator bits shift out, quotient bits shift in
  logic [CNT_W-1:0]  cnt_r;
  logic [GAIN_W-1:0] k_r;
  logic signed [51:0] prod_r;
  logic [MEAS_W-1:0] nx_r;

  // output register
  logic              out_valid_r;
  logic [CH_W-1:0]   out_chan_r;
  logic [MEAS_W-1:0] out_est_r;
  logic [GAIN_W-1:0] out_gain_r;

  // handshakes
  logic in_fire, cfg_fire, out_free, in_range;
  logic [EXT_W-1:0] ch_ext;
  logic [IDX_W-1:0] idx_in;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign ch_ext   = EXT_W'(in_ch.channel);
  assign idx_in   = ch_ext[IDX_W-1:0];
  assign in_range = (int'(in_ch.channel) < NUM_CHANNELS);

  // prediction: previous variance plus process noise, saturating
  logic [VAR_W-1:0]  var_cur;
  logic [VAR_W:0]    pp_sum;
  logic [VAR_W-1:0]  pp_pred;
  assign var_cur = vld_rd_r ? var_rd_r : VAR_ONE;
  assign pp_sum  = {1'b0, var_cur} + {1'b0, q_r};
  assign pp_pred = pp_sum[VAR_W] ? VAR_MAX : pp_sum[VAR_W-1:0];

  // gain numerator pp*65536 + den/2, split into initial remainder and shifted-in bits
  logic [VAR_W:0] den_nxt;
  logic [40:0]    num;
  assign den_nxt = {1'b0, pp_r} + {1'b0, r_r};
  assign num     = {1'b0, pp_r, 16'b0} + {17'b0, den_nxt[VAR_W:1]};

  // one restoring divide step
  logic [VAR_W+1:0] div_t;
  logic             div_ge;
  logic [VAR_W:0]   rem_step;
  assign div_t    = {rem_r, quo_r[GAIN_W-1]};
  assign div_ge   = (div_t >= {1'b0, den_r});
  assign rem_step = div_ge ? (VAR_W+1)'(div_t - {1'b0, den_r}) : div_t[VAR_W:0];

  // shared multiplier: k*(m-x) first, then (1-k)*pp
  logic              mul_sel;
  logic [MEAS_W:0]   diff;
  logic [GAIN_W-1:0] one_minus_k;
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] mul_p;
  assign mul_sel     = (state_r == S_MUL2);
  assign diff        = {meas_r[MEAS_W-1], meas_r} - {x_r[MEAS_W-1], x_r};
  assign one_minus_k = GAIN_ONE - k_r;
  assign mul_a = $signed({1'b0, (mul_sel ? one_minus_k : k_r)});
  assign mul_b = mul_sel ? $signed({10'b0, pp_r}) : $signed({diff[MEAS_W], diff});
  assign mul_p = mul_a * mul_b;

  // rounding of the registered product, floor division by 65536
  logic signed [51:0] prod_rnd;
  logic signed [51:0] prod_sh;
  logic signed [35:0] nx_full;
  logic [MEAS_W-1:0]  nx_sat;
  logic [VAR_W-1:0]   var_new;
  assign prod_rnd = prod_r + 52'sd32768;
  assign prod_sh  = prod_rnd >>> 16;
  assign nx_full  = $signed({{4{x_r[MEAS_W-1]}}, x_r}) + prod_sh[35:0];
  always_comb begin
    if (nx_full[35:31] == 5'b00000 || nx_full[35:31] == 5'b11111) begin
      nx_sat = nx_full[31:0];
    end else if (nx_full[35]) begin
      nx_sat = 32'h8000_0000;
    end else begin
      nx_sat = 32'h7FFF_FFFF;
    end
  end
  // (1-k)*pp rounded never exceeds pp, so the low 24 bits of the shifted value hold it
  assign var_new = prod_rnd[39:16];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_range) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_INIT;
      S_INIT: begin
        // zero denominator skips the divide with k = 0
        state_nxt = (den_nxt == '0) ? S_MUL1 : S_DIV;
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_MUL1;
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_UPD;
      S_UPD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      q_r         <= PROCESS_NOISE_RST;
      r_r         <= MEASUREMENT_NOISE_RST;
      init_est_r  <= INITIAL_ESTIMATE_RST;
      vld_r       <= '0;
      vld_rd_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_ch.index)
          REG_PROCESS_NOISE:     q_r <= cfg_ch.data[VAR_W-1:0];
          REG_MEASUREMENT_NOISE: r_r <= cfg_ch.data[VAR_W-1:0];
          REG_INITIAL_ESTIMATE: begin
            // reload every channel
            init_est_r <= cfg_ch.data;
            vld_r      <= '0;
          end
          default: ;
        endcase
      end
      if (in_fire) vld_rd_r <= vld_r[idx_in];
      if (state_r == S_INIT) cnt_r <= '0;
      else if (state_r == S_DIV) cnt_r <= cnt_r + 1'b1;
      if (state_r == S_UPD && out_free) begin
        vld_r[idx_r] <= 1'b1;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-channel stores, registered read at acceptance, write at update
  always_ff @(posedge clk) begin
    if (in_fire) begin
      est_rd_r <= est_mem[idx_in];
      var_rd_r <= var_mem[idx_in];
    end
    if (state_r == S_UPD && out_free) begin
      est_mem[idx_r] <= nx_r;
      var_mem[idx_r] <= var_new;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ch_r   <= in_ch.channel;
        idx_r  <= idx_in;
        meas_r <= in_ch.measurement;
      end
      S_READ: begin
        x_r  <= vld_rd_r ? est_rd_r : init_est_r;
        pp_r <= pp_pred;
      end
      S_INIT: begin
        den_r <= den_nxt;
        rem_r <= {1'b0, num[40:17]};
        quo_r <= num[16:0];
        k_r   <= '0;
      end
      S_DIV: begin
        rem_r <= rem_step;
        quo_r <= {quo_r[GAIN_W-2:0], div_ge};
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) k_r <= {quo_r[GAIN_W-2:0], div_ge};
      end
      S_MUL1: prod_r <= mul_p;
      S_MUL2: begin
        nx_r   <= nx_sat;
        prod_r <= mul_p;
      end
      default: ;
    endcase
    if (state_r == S_UPD && out_free) begin
      out_chan_r <= ch_r;
      out_est_r  <= nx_r;
      out_gain_r <= k_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.channel_out = out_chan_r;
  assign out_ch.estimate    = out_est_r;
  assign out_ch.gain        = out_gain_r;

  // checks

  // the gain is a fraction in [0, 1]
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.gain <= GAIN_ONE))
    else $error("gain above one");

  // updated variance never grows beyond the predicted variance
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (var_new <= pp_r))
    else $error("variance update exceeds prediction");

  // the divide counter stays within its step count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divide counter overrun");

  // an in-range request always starts the store read
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_range) |=> (state_r == S_READ))
    else $error("accepted request not started");

endmodule
